// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types, constants and value check of the UTF-8 sanitizing decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int CP_W    = 21;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_MB   = 21'h0000A0;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_3B   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B   = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            end_of_text;
    logic            last_of_item;
  } res_t;

  // results caused by one byte, in order: res0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } dec_out_t;

  function automatic logic value_bad(logic [CP_W-1:0] c, logic [2:0] len);
    value_bad = (c < MIN_MB)
             || (c >= SURR_LO && c <= SURR_HI)
             || (len == LEN_3 && c < MIN_3B)
             || (len == LEN_4 && c < MIN_4B)
             || (c > MAX_CP);
  endfunction

endpackage

// ===== hw/rtl/utf8_sanitizing_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizing_decoder
// UTF-8 byte stream in, sanitized Unicode code points out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and decoded in the same cycle into zero, one or
// two results, which go into a four-entry result queue; the output side gives
// one result beat per cycle from the queue head. Sustained rate is one byte
// per cycle as long as each byte yields at most one result; a byte that
// yields two (a broken sequence followed by a byte that decodes on its own)
// costs one extra output beat. in_stall rises when the queue holds more than
// two results, so it follows output backpressure after a short lag. Invalid
// input becomes U+FFFD with out_replaced set; a zero byte closes the text with
// code point 0 and out_end_of_text set, after a U+FFFD if a sequence was open.
module utf8_sanitizing_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u8sd_pkg::CP_W-1:0]  out_code_point,
  output logic                       out_replaced,
  output logic                       out_end_of_text,
  output logic                       out_last_of_item
);

  logic               accept;
  logic               no_room;
  logic [1:0]         push_n;
  u8sd_pkg::dec_out_t dec;

  assign in_stall = no_room;
  assign accept   = in_valid && !no_room;
  assign push_n   = accept ? dec.n : 2'd0;

  u8sd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_byte_in),
    .dec     (dec)
  );

  u8sd_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .push_n           (push_n),
    .res0             (dec.res0),
    .res1             (dec.res1),
    .no_room          (no_room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_replaced     (out_replaced),
    .out_end_of_text  (out_end_of_text),
    .out_last_of_item (out_last_of_item)
  );

endmodule

// ===== hw/rtl/u8sd_decode.sv =====
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  output u8sd_pkg::dec_out_t  dec
);

  logic [2:0]                  seq_r, seq_nxt;
  logic [2:0]                  seen_r, seen_nxt;
  logic [u8sd_pkg::CP_W-1:0]   acc_r, acc_nxt;
  logic                        tail_r, tail_nxt;

  logic                        cont;
  logic                        fr_v;
  u8sd_pkg::res_t              fr_res;
  logic [2:0]                  fr_seq;
  logic [2:0]                  fr_seen;
  logic [u8sd_pkg::CP_W-1:0]   fr_acc;
  logic                        fr_tail;

  assign cont = (byte_in[7:6] == 2'b10);

  // decode of a byte with no sequence pending
  always_comb begin
    fr_v    = 1'b0;
    fr_res  = '0;
    fr_seq  = u8sd_pkg::LEN_NONE;
    fr_seen = 3'd0;
    fr_acc  = '0;
    fr_tail = 1'b0;
    if (cont) begin
      fr_tail = 1'b1;
      if (!tail_r) begin
        fr_v                = 1'b1;
        fr_res.code_point   = u8sd_pkg::REPL_CP;
        fr_res.replaced     = 1'b1;
      end
    end else if (byte_in == 8'h00) begin
      fr_v               = 1'b1;
      fr_res.end_of_text = 1'b1;
    end else if (!byte_in[7]) begin
      fr_v              = 1'b1;
      fr_res.code_point = {13'd0, byte_in};
    end else if (byte_in[7:5] == 3'b110) begin
      fr_seq  = u8sd_pkg::LEN_2;
      fr_seen = 3'd1;
      fr_acc  = {16'd0, byte_in[4:0]};
    end else if (byte_in[7:4] == 4'b1110) begin
      fr_seq  = u8sd_pkg::LEN_3;
      fr_seen = 3'd1;
      fr_acc  = {17'd0, byte_in[3:0]};
    end else if (byte_in[7:3] == 5'b11110) begin
      fr_seq  = u8sd_pkg::LEN_4;
      fr_seen = 3'd1;
      fr_acc  = {18'd0, byte_in[2:0]};
    end else begin
      fr_v              = 1'b1;
      fr_res.code_point = u8sd_pkg::REPL_CP;
      fr_res.replaced   = 1'b1;
    end
  end

  always_comb begin
    logic use_fresh;
    use_fresh = 1'b0;
    seq_nxt   = seq_r;
    seen_nxt  = seen_r;
    acc_nxt   = acc_r;
    tail_nxt  = tail_r;
    dec       = '0;
    if (seq_r != u8sd_pkg::LEN_NONE) begin
      if (cont) begin
        acc_nxt  = {acc_r[u8sd_pkg::CP_W-7:0], byte_in[5:0]};
        seen_nxt = 3'(seen_r + 3'd1);
        if (seen_nxt >= seq_r) begin
          dec.n = 2'd1;
          if (u8sd_pkg::value_bad(acc_nxt, seq_r)) begin
            dec.res0.code_point = u8sd_pkg::REPL_CP;
            dec.res0.replaced   = 1'b1;
          end else begin
            dec.res0.code_point = acc_nxt;
          end
          seq_nxt  = u8sd_pkg::LEN_NONE;
          seen_nxt = 3'd0;
          acc_nxt  = '0;
        end
      end else begin
        // broken sequence: replacement, then the byte starts over
        dec.n               = 2'd1;
        dec.res0.code_point = u8sd_pkg::REPL_CP;
        dec.res0.replaced   = 1'b1;
        use_fresh           = 1'b1;
      end
    end else begin
      use_fresh = 1'b1;
    end

    if (use_fresh) begin
      seq_nxt  = fr_seq;
      seen_nxt = fr_seen;
      acc_nxt  = fr_acc;
      tail_nxt = fr_tail;
      if (fr_v) begin
        if (dec.n == 2'd0) begin
          dec.res0 = fr_res;
        end else begin
          dec.res1 = fr_res;
        end
        dec.n = 2'(dec.n + 2'd1);
      end
    end

    if (dec.n == 2'd2) begin
      dec.res1.last_of_item = 1'b1;
    end else begin
      dec.res0.last_of_item = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= u8sd_pkg::LEN_NONE;
      seen_r <= 3'd0;
      acc_r  <= '0;
      tail_r <= 1'b0;
    end else if (accept) begin
      seq_r  <= seq_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
      tail_r <= tail_nxt;
    end
  end

endmodule

// ===== hw/rtl/u8sd_outq.sv =====
// ----------------------------------------------------------------------------
// u8sd_outq
// Result queue: takes up to two results per cycle, gives one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module u8sd_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_n,
  input  u8sd_pkg::res_t             res0,
  input  u8sd_pkg::res_t             res1,
  output logic                       no_room,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u8sd_pkg::CP_W-1:0]  out_code_point,
  output logic                       out_replaced,
  output logic                       out_end_of_text,
  output logic                       out_last_of_item
);

  u8sd_pkg::res_t               mem [u8sd_pkg::Q_DEPTH];
  logic [u8sd_pkg::Q_AW-1:0]    wptr_r, wptr_nxt;
  logic [u8sd_pkg::Q_AW-1:0]    rptr_r, rptr_nxt;
  logic [u8sd_pkg::Q_CW-1:0]    cnt_r, cnt_nxt;
  logic [u8sd_pkg::Q_AW-1:0]    wptr_p1;
  logic                         pop;
  u8sd_pkg::res_t               head;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  // keep room for a two-result byte
  assign no_room   = (cnt_r > u8sd_pkg::Q_CW'(u8sd_pkg::Q_DEPTH - 2));
  assign wptr_p1   = u8sd_pkg::Q_AW'(wptr_r + 1'b1);

  assign wptr_nxt = u8sd_pkg::Q_AW'(wptr_r + u8sd_pkg::Q_AW'(push_n));
  assign rptr_nxt = pop ? u8sd_pkg::Q_AW'(rptr_r + 1'b1) : rptr_r;
  assign cnt_nxt  = u8sd_pkg::Q_CW'(cnt_r + u8sd_pkg::Q_CW'(push_n)
                    - u8sd_pkg::Q_CW'(pop));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      mem[wptr_p1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign head             = mem[rptr_r];
  assign out_code_point   = head.code_point;
  assign out_replaced     = head.replaced;
  assign out_end_of_text  = head.end_of_text;
  assign out_last_of_item = head.last_of_item;

endmodule

// ===== hw/rtl/u8sd_checker.sv =====
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level assertions for the UTF-8 sanitizing decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8sd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [7:0]                 in_byte_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [u8sd_pkg::CP_W-1:0]  out_code_point,
  input logic                       out_replaced,
  input logic                       out_end_of_text,
  input logic                       out_last_of_item
);

  // a stalled result beat holds
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_code_point) && $stable(out_last_of_item))
  // end of text is code point 0, never a replacement, and closes its byte
  `AST_IMPL(a_eot_form, clk, rst_n, out_valid && out_end_of_text, out_code_point == '0 && !out_replaced && out_last_of_item)
  // replacements always carry U+FFFD
  `AST_IMPL(a_repl_cp, clk, rst_n, out_valid && out_replaced, out_code_point == u8sd_pkg::REPL_CP)
  // an accepted ASCII byte on an empty output leaves a result behind it
  `AST_NEXT(a_ascii_out, clk, rst_n, in_valid && !in_stall && in_byte_in[7] == 1'b0 && !out_valid, out_valid)

endmodule

bind utf8_sanitizing_decoder u8sd_checker u_u8sd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_byte_in       (in_byte_in),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_code_point   (out_code_point),
  .out_replaced     (out_replaced),
  .out_end_of_text  (out_end_of_text),
  .out_last_of_item (out_last_of_item)
);

// ===== dv/tb_utf8_sanitizing_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_sanitizing_decoder
// Self-checking bench for the UTF-8 sanitizing decoder.
// ----------------------------------------------------------------------------
// A directed byte string hits the corners first: limits of each sequence
// length, surrogates, overlong forms, stray tails, bad leads, broken
// sequences and end of text. Mostly well-formed sequences with random code
// points follow, mixed with truncated sequences and raw noise. Each accepted
// byte runs through a local decoder model, and every result beat is checked
// in order against it. Both sides insert random idle bursts.
module tb_utf8_sanitizing_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 550;
  localparam int N_DIRECTED  = 24;
  localparam int QUIET_TAIL  = 60;

  // corner string, sent left to right
  localparam logic [8*N_DIRECTED-1:0] DIRECTED = {
    8'hC2, 8'hA0,                // smallest value allowed in two bytes
    8'hEF, 8'hBF, 8'hBD,         // U+FFFD spelled out, not a replacement
    8'hED, 8'hA0, 8'h80,         // surrogate
    8'hF4, 8'h90, 8'h80, 8'h80,  // above U+10FFFF
    8'h80, 8'hBF,                // stray tail run: one replacement
    8'hFF,                       // bad lead
    8'hC3, 8'h41,                // broken by ASCII: two results
    8'hE2, 8'h82, 8'h00,         // end of text with a sequence open
    8'h7F,
    8'hE0, 8'h80, 8'h80          // overlong three-byte form
  };

  typedef struct packed {
    logic       hold;  // wait for all results before sending this byte
    logic [7:0] b;
  } stim_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_byte_in = 8'h00;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [u8sd_pkg::CP_W-1:0]     out_code_point;
  logic                          out_replaced;
  logic                          out_end_of_text;
  logic                          out_last_of_item;

  utf8_sanitizing_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_replaced     (out_replaced),
    .out_end_of_text  (out_end_of_text),
    .out_last_of_item (out_last_of_item)
  );

  always #4 clk = ~clk;

  stim_t           byte_q[$];
  u8sd_pkg::res_t  pending_cps[$];
  logic            hold_next = 1'b0;

  // decoder model state
  logic [2:0]                seq_len = u8sd_pkg::LEN_NONE;
  logic [2:0]                seen = 3'd0;
  logic [u8sd_pkg::CP_W-1:0] acc = '0;
  logic                      tail_run = 1'b0;
  u8sd_pkg::res_t            step_res [0:1];
  int                        step_n;

  int errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_repl = 0;
  int n_eot = 0;
  int n_double = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------- model
  function automatic void emit(logic [u8sd_pkg::CP_W-1:0] cp, logic rep, logic eot);
    step_res[step_n].code_point   = cp;
    step_res[step_n].replaced     = rep;
    step_res[step_n].end_of_text  = eot;
    step_res[step_n].last_of_item = 1'b0;
    step_n++;
  endfunction

  // byte seen with no sequence open
  function automatic void start_byte(logic [7:0] b);
    if (b[7:6] == 2'b10) begin
      if (!tail_run) begin
        emit(u8sd_pkg::REPL_CP, 1'b1, 1'b0);
        tail_run = 1'b1;
      end
    end else begin
      tail_run = 1'b0;
      if (b == 8'h00) begin
        emit('0, 1'b0, 1'b1);
        seq_len = u8sd_pkg::LEN_NONE;
        seen = 3'd0;
        acc = '0;
      end else if (!b[7]) begin
        emit({13'd0, b}, 1'b0, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        seq_len = u8sd_pkg::LEN_2;
        acc = {16'd0, b[4:0]};
        seen = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_len = u8sd_pkg::LEN_3;
        acc = {17'd0, b[3:0]};
        seen = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
        seq_len = u8sd_pkg::LEN_4;
        acc = {18'd0, b[2:0]};
        seen = 3'd1;
      end else begin
        emit(u8sd_pkg::REPL_CP, 1'b1, 1'b0);
      end
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic bad;
    step_n = 0;
    if (seq_len != u8sd_pkg::LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        acc = {acc[u8sd_pkg::CP_W-7:0], b[5:0]};
        seen = seen + 3'd1;
        if (seen >= seq_len) begin
          bad = (acc < u8sd_pkg::MIN_MB)
             || (acc >= u8sd_pkg::SURR_LO && acc <= u8sd_pkg::SURR_HI)
             || (seq_len == u8sd_pkg::LEN_3 && acc < u8sd_pkg::MIN_3B)
             || (seq_len == u8sd_pkg::LEN_4 && acc < u8sd_pkg::MIN_4B)
             || (acc > u8sd_pkg::MAX_CP);
          if (bad) emit(u8sd_pkg::REPL_CP, 1'b1, 1'b0);
          else emit(acc, 1'b0, 1'b0);
          seq_len = u8sd_pkg::LEN_NONE;
          seen = 3'd0;
          acc = '0;
        end
      end else begin
        emit(u8sd_pkg::REPL_CP, 1'b1, 1'b0);
        seq_len = u8sd_pkg::LEN_NONE;
        seen = 3'd0;
        acc = '0;
        start_byte(b);
      end
    end else begin
      start_byte(b);
    end
    if (step_n > 0) step_res[step_n-1].last_of_item = 1'b1;
    if (step_n == 2) n_double++;
    for (int i = 0; i < step_n; i++) pending_cps = {pending_cps, step_res[i]};
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic void add_byte(logic [7:0] b);
    stim_t s;
    s.hold = hold_next;
    s.b = b;
    hold_next = 1'b0;
    byte_q = {byte_q, s};
  endfunction

  // encode cp in len bytes, send only the first keep of them
  function automatic void push_seq(logic [u8sd_pkg::CP_W-1:0] cp, int len, int keep);
    logic [7:0] seq [0:3];
    seq[1] = {2'b10, cp[5:0]};
    case (len)
      2: begin
        seq[0] = {3'b110, cp[10:6]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) add_byte(seq[i]);
  endfunction

  // --------------------------------------------------------------- driver
  int gap_left = 0;
  int calm_in = 0;
  logic in_fire;
  stim_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        decode_byte(in_byte_in);
        n_bytes++;
      end
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0
                     || (byte_q[0].hold && pending_cps.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (calm_in == 0 && byte_q.size() > QUIET_TAIL
                     && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 19) - 1;
          if ($urandom_range(0, 3) == 0) calm_in = $urandom_range(30, 120);
          in_valid <= 1'b0;
        end else begin
          if (calm_in > 0) calm_in--;
          next_item = byte_q.pop_front();
          in_byte_in <= next_item.b;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor
  int stall_left = 0;
  int calm_out = 0;
  u8sd_pkg::res_t want;

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_cps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual code point %h",
                   $time, out_code_point);
          errors++;
        end else begin
          want = pending_cps.pop_front();
          check_field("code_point", int'(want.code_point), int'(out_code_point));
          check_field("replaced", int'(want.replaced), int'(out_replaced));
          check_field("end_of_text", int'(want.end_of_text), int'(out_end_of_text));
          check_field("last_of_item", int'(want.last_of_item), int'(out_last_of_item));
          n_results++;
          if (out_replaced) n_repl++;
          if (out_end_of_text) n_eot++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm_out == 0 && byte_q.size() > QUIET_TAIL
                   && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        if ($urandom_range(0, 3) == 0) calm_out = $urandom_range(30, 120);
        out_stall <= 1'b1;
      end else begin
        if (calm_out > 0) calm_out--;
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_cps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequence
  initial begin
    int pick;
    int len;
    logic [u8sd_pkg::CP_W-1:0] cp;

    for (int i = N_DIRECTED - 1; i >= 0; i--) add_byte(DIRECTED[i*8 +: 8]);
    hold_next = 1'b1;  // let the directed part drain before random traffic
    while (byte_q.size() < N_DIRECTED + N_RANDOM) begin
      if ($urandom_range(0, 119) == 0) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        add_byte(8'($urandom_range(1, 127)));
      end else if (pick < 28) begin
        push_seq(21'($urandom_range(21'h80, 21'h7FF)), 2, 2);
      end else if (pick < 44) begin
        cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 21'hFFFF))
                                         : 21'($urandom_range(21'h800, 21'hFFFF));
        push_seq(cp, 3, 3);
      end else if (pick < 58) begin
        cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 21'h1FFFFF))
                                         : 21'($urandom_range(21'h10000, 21'h10FFFF));
        push_seq(cp, 4, 4);
      end else if (pick < 68) begin
        // values on either side of each limit
        case ($urandom_range(0, 13))
          0:  push_seq(21'h9F, 2, 2);
          1:  push_seq(21'hA0, 2, 2);
          2:  push_seq(21'h7FF, 2, 2);
          3:  push_seq(21'h7FF, 3, 3);
          4:  push_seq(21'h800, 3, 3);
          5:  push_seq(21'hD7FF, 3, 3);
          6:  push_seq(21'hD800, 3, 3);
          7:  push_seq(21'hDFFF, 3, 3);
          8:  push_seq(21'hE000, 3, 3);
          9:  push_seq(21'hFFFF, 3, 3);
          10: push_seq(21'hFFFF, 4, 4);
          11: push_seq(21'h10000, 4, 4);
          12: push_seq(21'h10FFFF, 4, 4);
          default: push_seq(21'h110000, 4, 4);
        endcase
      end else if (pick < 76) begin
        len = $urandom_range(2, 4);
        push_seq(21'($urandom_range(0, 21'h1FFFFF)), len, $urandom_range(1, len - 1));
      end else if (pick < 82) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) add_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 86) begin
        add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (pick < 90) begin
        add_byte(8'h00);
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("decoded %0d bytes into %0d code points: %0d replacements, %0d ends of text,",
             n_bytes, n_results, n_repl, n_eot);
    $display("%0d bytes gave two results; random idle on both sides until the tail",
             n_double);
    if (errors == 0 && pending_cps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== utf8_sanitizing_decoder.f =====
+incdir+hw/rtl
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/u8sd_outq.sv
hw/rtl/utf8_sanitizing_decoder.sv
hw/rtl/u8sd_checker.sv
dv/tb_utf8_sanitizing_decoder.sv
